/* sv/vrb_pkg.sv */
// ----------------------------------------------------------------------------
// vrb_pkg
// Shared types and constants of the volatility ratio breakout detector.
// ----------------------------------------------------------------------------
package vrb_pkg;

	// sample and result field widths
	localparam int SAMPLE_W = 16;
	localparam int VOL_W    = 16;
	localparam int COUNT_W  = 32;
	localparam int OUT_W    = 152;

	// default store depths
	localparam int DEF_SHORT_DEPTH = 16;
	localparam int DEF_LONG_DEPTH  = 64;

	// configuration register widths and reset values
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [4:0]  RST_SHORT_WINDOW = 5'd16;
	localparam logic [6:0]  RST_LONG_WINDOW  = 7'd64;
	localparam logic [6:0]  RST_MIN_SAMPLES  = 7'd16;
	localparam logic [15:0] RST_BREAKOUT     = 16'd512;
	localparam logic [15:0] RST_CONTRACTION  = 16'd128;

	// ratio constants, Q8.8
	localparam logic [15:0] RATIO_ONE = 16'd256;
	localparam logic [15:0] RATIO_MAX = 16'hFFFF;

	// iteration counts of the shared divider and the square root unit
	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;
	localparam int STEP_W     = 5;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_WINDOW      = 3'd0,
		CFG_LONG_WINDOW       = 3'd1,
		CFG_MIN_SAMPLES       = 3'd2,
		CFG_BREAKOUT_RATIO    = 3'd3,
		CFG_CONTRACTION_RATIO = 3'd4
	} cfg_idx_t;

	// configuration seen by the engine
	typedef struct packed {
		logic [4:0]  short_len;
		logic [6:0]  long_len;
		logic [6:0]  min_fill;
		logic [15:0] expand_thresh;
		logic [15:0] contract_thresh;
		logic        restart;
	} vrb_cfg_t;

	// engine sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_MUL,
		ST_DIVLD,
		ST_DIV,
		ST_SQLD,
		ST_SQRT,
		ST_NEXT,
		ST_RLD,
		ST_RSAT,
		ST_FLAGS,
		ST_FINISH
	} vrb_state_t;

endpackage

/* sv/volatility_ratio_breakout_detector.sv */
// ----------------------------------------------------------------------------
// volatility_ratio_breakout_detector
// Rolling short/long standard deviation ratio with breakout event flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed Q4.12 sample per request into a two-entry queue.
//   m_* returns one result per sample: both deviations, the Q8.8 ratio,
//   the expansion and contraction flags and three wrapping counters.
//   cfg_* writes a register by index; the user must do so while the block is
//   idle, not enforced; any known index restarts both windows, others ignored.
// Sequencing:
//   a sample that is not evaluated goes straight to its result; for an
//   evaluated one the engine sweeps both stores, one entry per cycle, then
//   runs each window through the 31-step divider and the 16-step square
//   root and the ratio through the divider again. A window holding fewer
//   than two entries skips its divide and square root, a zero long
//   deviation skips the ratio divide. The engine takes one sample at a time.
// Reset: windows empty, registers at their defaults, counters zero.
// Stall: while m_tready is low the result waits in the output register,
//   the engine holds at its last step and the queue takes up to two more.
// ----------------------------------------------------------------------------
module volatility_ratio_breakout_detector
	import vrb_pkg::*;
#(
	parameter int SHORT_DEPTH = DEF_SHORT_DEPTH,
	parameter int LONG_DEPTH  = DEF_LONG_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,    // sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// short deviation, long deviation, ratio, expansion_event,
	// contraction_event, expansion_count, contraction_count, sample_count,
	// zero pad
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	vrb_cfg_t            cfg_q;
	logic                q_valid;
	logic                q_ready;
	logic [SAMPLE_W-1:0] q_sample;
	logic                cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// configuration registers and restart request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_len       <= RST_SHORT_WINDOW;
			cfg_q.long_len        <= RST_LONG_WINDOW;
			cfg_q.min_fill        <= RST_MIN_SAMPLES;
			cfg_q.expand_thresh   <= RST_BREAKOUT;
			cfg_q.contract_thresh <= RST_CONTRACTION;
			cfg_q.restart         <= 1'b0;
		end else begin
			cfg_q.restart <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_SHORT_WINDOW: begin
						cfg_q.short_len <= cfg_data[4:0];
						cfg_q.restart   <= 1'b1;
					end
					CFG_LONG_WINDOW: begin
						cfg_q.long_len <= cfg_data[6:0];
						cfg_q.restart  <= 1'b1;
					end
					CFG_MIN_SAMPLES: begin
						cfg_q.min_fill <= cfg_data[6:0];
						cfg_q.restart  <= 1'b1;
					end
					CFG_BREAKOUT_RATIO: begin
						cfg_q.expand_thresh <= cfg_data;
						cfg_q.restart       <= 1'b1;
					end
					CFG_CONTRACTION_RATIO: begin
						cfg_q.contract_thresh <= cfg_data;
						cfg_q.restart         <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// front: sample queue
	vrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_sample)
	);

	// back: statistics engine
	vrb_core #(
		.SHORT_DEPTH (SHORT_DEPTH),
		.LONG_DEPTH  (LONG_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_sample (q_sample),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* sv/vrb_queue.sv */
// ----------------------------------------------------------------------------
// vrb_queue
// Two-entry sample queue between the input channel and the engine.
// ----------------------------------------------------------------------------
module vrb_queue
	import vrb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] out_data
);

	logic [SAMPLE_W-1:0] slot_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          count_q;
	logic                push;
	logic                pop;

	// handshake
	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* sv/vrb_core.sv */
// ----------------------------------------------------------------------------
// vrb_core
// Window stores, statistics sweep, shared divider, square root and event logic.
// ----------------------------------------------------------------------------
module vrb_core
	import vrb_pkg::*;
#(
	parameter int SHORT_DEPTH = DEF_SHORT_DEPTH,
	parameter int LONG_DEPTH  = DEF_LONG_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vrb_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_W-1:0]    out_data
);

	localparam int SAW  = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
	localparam int LAW  = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
	localparam int SFW  = $clog2(SHORT_DEPTH + 1);
	localparam int LFW  = $clog2(LONG_DEPTH + 1);
	localparam int MAXD = (SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH;
	localparam int NW   = $clog2(MAXD + 1);
	localparam int S1W  = SAMPLE_W + NW;
	localparam int S2W  = 2 * SAMPLE_W - 1 + NW;
	localparam int NUMW = 2 * NW + 2 * SAMPLE_W - 1;
	localparam int QW   = DIV_STEPS;
	localparam int RW   = 2 * SQRT_STEPS;

	vrb_state_t state_q, state_d;

	logic [SAMPLE_W-1:0] short_mem [SHORT_DEPTH];
	logic [SAMPLE_W-1:0] long_mem  [LONG_DEPTH];

	logic [SAW-1:0] shead_q;
	logic [LAW-1:0] lhead_q;
	logic [SFW-1:0] sfill_q;
	logic [LFW-1:0] lfill_q;
	logic [SFW-1:0] sw;
	logic [LFW-1:0] lw;
	logic [SFW-1:0] shead_inc;
	logic [LAW:0]   lhead_inc;
	logic [SFW-1:0] sfill_nx;
	logic [LFW-1:0] lfill_nx;
	logic           eval;

	logic [NW-1:0]  cnt_q;
	logic [NW-1:0]  nmax;
	logic [NW-1:0]  sfill_n;
	logic [NW-1:0]  lfill_n;
	logic           srd_s1, lrd_s1;
	logic [SAMPLE_W-1:0] srdata_s1, lrdata_s1;
	logic signed [S1W-1:0] ssum_q, lsum_q;
	logic [S2W-1:0] ssq_q, lsq_q;

	logic           win_q;
	logic [NW-1:0]  n_sel;
	logic signed [S1W-1:0] s1_sel;
	logic [S2W-1:0] s2_sel;
	logic [S1W-1:0] mag;
	logic [NUMW-1:0] p1_q, p2_q;
	logic [2*NW-1:0] nn_q;

	logic [NUMW-1:0] rem_q, dsh_q;
	logic [QW-1:0]   quo_q;
	logic [STEP_W-1:0] step_q;
	logic            div_ratio_q;
	logic            div_ge;

	logic [RW-1:0]   sx_q, sres_q, sbit_q;
	logic [RW-1:0]   sq_try;
	logic            sq_ge;

	logic [VOL_W-1:0] sv_q, lv_q, ratio_q;
	logic             was_exp_q, was_con_q;
	logic             exp_ev_q, con_ev_q;
	logic [COUNT_W-1:0] exp_total_q, con_total_q, rec_total_q;
	logic             expansion, contraction;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             accept;
	logic             load_out;

	// effective window lengths
	always_comb begin
		if (cfg.short_len == '0) begin
			sw = SFW'(1);
		end else if (32'(cfg.short_len) > SHORT_DEPTH) begin
			sw = SFW'(SHORT_DEPTH);
		end else begin
			sw = SFW'(cfg.short_len);
		end
		if (cfg.long_len == '0) begin
			lw = LFW'(1);
		end else if (32'(cfg.long_len) > LONG_DEPTH) begin
			lw = LFW'(LONG_DEPTH);
		end else begin
			lw = LFW'(cfg.long_len);
		end
	end

	// ring heads and fills after this sample
	assign shead_inc = SFW'(shead_q) + SFW'(1);
	assign lhead_inc = (LAW+1)'(lhead_q) + (LAW+1)'(1);
	assign sfill_nx  = (sfill_q < sw) ? sfill_q + SFW'(1) : sfill_q;
	assign lfill_nx  = (lfill_q < lw) ? lfill_q + LFW'(1) : lfill_q;
	assign eval      = 32'(lfill_nx) >= 32'(cfg.min_fill);
	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign in_ready  = (state_q == ST_IDLE);

	// sweep bounds
	assign sfill_n = NW'(sfill_q);
	assign lfill_n = NW'(lfill_q);
	assign nmax    = (sfill_n > lfill_n) ? sfill_n : lfill_n;

	// window selection for the deviation path
	assign n_sel  = win_q ? lfill_n : sfill_n;
	assign s1_sel = win_q ? lsum_q : ssum_q;
	assign s2_sel = win_q ? lsq_q : ssq_q;
	assign mag    = s1_sel[S1W-1] ? S1W'(-s1_sel) : S1W'(s1_sel);

	// divider and square root step compares
	assign div_ge = rem_q >= dsh_q;
	assign sq_try = sres_q + sbit_q;
	assign sq_ge  = sx_q >= sq_try;

	// event conditions
	assign expansion   = ratio_q > cfg.expand_thresh;
	assign contraction = ratio_q < cfg.contract_thresh;

	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = eval ? ST_SWEEP : ST_FINISH;
				end
			end
			ST_SWEEP: begin
				if (cnt_q == nmax) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = (n_sel < NW'(2)) ? ST_NEXT : ST_DIVLD;
			end
			ST_DIVLD: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = div_ratio_q ? ST_RSAT : ST_SQLD;
				end
			end
			ST_SQLD: state_d = ST_SQRT;
			ST_SQRT: begin
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: state_d = win_q ? ST_RLD : ST_MUL;
			ST_RLD: state_d = (lv_q == '0) ? ST_FLAGS : ST_DIV;
			ST_RSAT: state_d = ST_FLAGS;
			ST_FLAGS: state_d = ST_FINISH;
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window stores and their registered reads
	always_ff @(posedge clk) begin
		if (accept) begin
			short_mem[shead_q] <= in_sample;
			long_mem[lhead_q]  <= in_sample;
		end
		if (state_q == ST_SWEEP && cnt_q < sfill_n) begin
			srdata_s1 <= short_mem[cnt_q[SAW-1:0]];
		end
		if (state_q == ST_SWEEP && cnt_q < lfill_n) begin
			lrdata_s1 <= long_mem[cnt_q[LAW-1:0]];
		end
	end

	// ring control and sweep flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shead_q <= '0;
			lhead_q <= '0;
			sfill_q <= '0;
			lfill_q <= '0;
			srd_s1  <= 1'b0;
			lrd_s1  <= 1'b0;
		end else begin
			if (cfg.restart) begin
				shead_q <= '0;
				lhead_q <= '0;
				sfill_q <= '0;
				lfill_q <= '0;
			end else if (accept) begin
				shead_q <= (shead_inc >= sw) ? '0 : SAW'(shead_inc);
				lhead_q <= ((LFW+1)'(lhead_inc) >= (LFW+1)'(lw)) ? '0 : LAW'(lhead_inc);
				sfill_q <= sfill_nx;
				lfill_q <= lfill_nx;
			end
			srd_s1 <= (state_q == ST_SWEEP) && (cnt_q < sfill_n);
			lrd_s1 <= (state_q == ST_SWEEP) && (cnt_q < lfill_n);
		end
	end

	// statistics, divider, square root and ratio datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cnt_q  <= '0;
				ssum_q <= '0;
				lsum_q <= '0;
				ssq_q  <= '0;
				lsq_q  <= '0;
				win_q  <= 1'b0;
				sv_q   <= '0;
				lv_q   <= '0;
				ratio_q <= RATIO_ONE;
			end
			ST_SWEEP: begin
				cnt_q <= cnt_q + NW'(1);
				if (srd_s1) begin
					ssum_q <= ssum_q + S1W'($signed(srdata_s1));
					ssq_q  <= ssq_q + S2W'($unsigned(32'($signed(srdata_s1))
						* 32'($signed(srdata_s1))));
				end
				if (lrd_s1) begin
					lsum_q <= lsum_q + S1W'($signed(lrdata_s1));
					lsq_q  <= lsq_q + S2W'($unsigned(32'($signed(lrdata_s1))
						* 32'($signed(lrdata_s1))));
				end
			end
			ST_MUL: begin
				p1_q   <= NUMW'(n_sel) * NUMW'(s2_sel);
				p2_q   <= NUMW'(mag) * NUMW'(mag);
				nn_q   <= (2*NW)'(n_sel) * (2*NW)'(n_sel);
				sres_q <= '0;
			end
			ST_DIVLD: begin
				rem_q       <= p1_q - p2_q;
				dsh_q       <= NUMW'(nn_q) << (DIV_STEPS - 1);
				quo_q       <= '0;
				step_q      <= '0;
				div_ratio_q <= 1'b0;
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q  <= {quo_q[QW-2:0], div_ge};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q + STEP_W'(1);
			end
			ST_SQLD: begin
				sx_q   <= RW'(quo_q);
				sres_q <= '0;
				sbit_q <= RW'(1) << (RW - 2);
				step_q <= '0;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					sx_q   <= sx_q - sq_try;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				step_q <= step_q + STEP_W'(1);
			end
			ST_NEXT: begin
				if (win_q) begin
					lv_q <= sres_q[VOL_W-1:0];
				end else begin
					sv_q <= sres_q[VOL_W-1:0];
				end
				win_q <= 1'b1;
			end
			ST_RLD: begin
				ratio_q     <= RATIO_ONE;
				rem_q       <= NUMW'({sv_q, 8'h00});
				dsh_q       <= NUMW'(lv_q) << (DIV_STEPS - 1);
				quo_q       <= '0;
				step_q      <= '0;
				div_ratio_q <= 1'b1;
			end
			ST_RSAT: begin
				ratio_q <= (quo_q > QW'(RATIO_MAX)) ? RATIO_MAX : quo_q[VOL_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// edge flags, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_exp_q   <= 1'b0;
			was_con_q   <= 1'b0;
			exp_ev_q    <= 1'b0;
			con_ev_q    <= 1'b0;
			exp_total_q <= '0;
			con_total_q <= '0;
			rec_total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rec_total_q <= rec_total_q + COUNT_W'(1);
				exp_ev_q    <= 1'b0;
				con_ev_q    <= 1'b0;
			end
			if (state_q == ST_FLAGS) begin
				exp_ev_q  <= expansion && !was_exp_q;
				con_ev_q  <= contraction && !was_con_q;
				was_exp_q <= expansion;
				was_con_q <= contraction;
				if (expansion && !was_exp_q) begin
					exp_total_q <= exp_total_q + COUNT_W'(1);
				end
				if (contraction && !was_con_q) begin
					con_total_q <= con_total_q + COUNT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {6'd0, rec_total_q, con_total_q, exp_total_q,
				con_ev_q, exp_ev_q, ratio_q, lv_q, sv_q};
		end
	end

	// fills stay within the stores
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(sfill_q) <= SHORT_DEPTH) && (32'(lfill_q) <= LONG_DEPTH))
		else $error("window fill beyond store depth");

	// a zero long deviation always shows the unit ratio
	a_unit_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && lv_q == '0) |-> (ratio_q == RATIO_ONE))
		else $error("ratio not unity for zero long deviation");

	// an expansion event is flagged together with a step of its counter
	a_event_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLAGS && expansion && !was_exp_q)
		|=> (exp_total_q == $past(exp_total_q) + COUNT_W'(1)))
		else $error("expansion event without count");

	// a new request is never taken while the engine is busy
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("request taken while busy");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the volatility ratio breakout detector: a
// directed table of samples and register writes, then random phases with
// bursty sample content, random idling on both streams and a long output
// hold-off. Every result is checked against an in-bench deviation model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import vrb_pkg::*;

	localparam int SDEPTH   = DEF_SHORT_DEPTH;
	localparam int LDEPTH   = DEF_LONG_DEPTH;
	localparam int WD_LIMIT = 20000;

	// last field sits in the lowest bits of m_tdata
	typedef struct packed {
		logic [31:0] sample_count;
		logic [31:0] contraction_count;
		logic [31:0] expansion_count;
		logic        contraction_event;
		logic        expansion_event;
		logic [15:0] dev_ratio;
		logic [15:0] long_dev;
		logic [15:0] short_dev;
	} vol_result_t;

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_KNOWN, ROW_WRITE} row_kind_t;

	// one row of the directed table; ROW_KNOWN carries typed deviations
	typedef struct {
		row_kind_t   kind;
		logic [2:0]  index;
		logic [15:0] value;
		logic [15:0] sv;
		logic [15:0] lv;
		logic [15:0] ratio;
		logic        exp_ev;
		logic        con_ev;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	volatility_ratio_breakout_detector i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow state of the detector
	logic [4:0]  m_short_len;
	logic [6:0]  m_long_len;
	logic [6:0]  m_min_fill;
	logic [15:0] m_breakout;
	logic [15:0] m_contraction;
	logic [15:0] short_mem [SDEPTH];
	logic [15:0] long_mem [LDEPTH];
	int          short_head, short_fill, long_head, long_fill;
	bit          was_expanding, was_contracting;
	logic [31:0] expansion_total, contraction_total, record_total;

	vol_result_t pending_results [$];
	int          fail_count = 0;
	int          result_count = 0;
	int          event_count = 0;
	int          write_count = 0;
	int          sender_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_cycles = 0;
	int          quiet_cycles = 0;

	function automatic void clear_windows();
		for (int i = 0; i < SDEPTH; i++) short_mem[i] = '0;
		for (int i = 0; i < LDEPTH; i++) long_mem[i] = '0;
		short_head = 0;
		short_fill = 0;
		long_head = 0;
		long_fill = 0;
	endfunction

	function automatic void model_reset();
		m_short_len = RST_SHORT_WINDOW;
		m_long_len = RST_LONG_WINDOW;
		m_min_fill = RST_MIN_SAMPLES;
		m_breakout = RST_BREAKOUT;
		m_contraction = RST_CONTRACTION;
		clear_windows();
		was_expanding = 0;
		was_contracting = 0;
		expansion_total = '0;
		contraction_total = '0;
		record_total = '0;
	endfunction

	function automatic void model_write(logic [2:0] idx, logic [15:0] val);
		case (idx)
			CFG_SHORT_WINDOW: m_short_len = val[4:0];
			CFG_LONG_WINDOW: m_long_len = val[6:0];
			CFG_MIN_SAMPLES: m_min_fill = val[6:0];
			CFG_BREAKOUT_RATIO: m_breakout = val;
			CFG_CONTRACTION_RATIO: m_contraction = val;
			default: return;
		endcase
		clear_windows();
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// truncated population deviation over the first n store entries
	function automatic logic [15:0] window_spread(bit from_long, int n);
		longint s1, s2, v;
		longint unsigned num;
		s1 = 0;
		s2 = 0;
		for (int i = 0; i < n; i++) begin
			v = from_long ? longint'($signed(long_mem[i])) : longint'($signed(short_mem[i]));
			s1 += v;
			s2 += v * v;
		end
		if (n < 2) return '0;
		num = longint'(n) * s2 - s1 * s1;
		return 16'(int_sqrt(num / (longint'(n) * n)));
	endfunction

	function automatic vol_result_t predict_sample(logic [15:0] s);
		vol_result_t r;
		int sw, lw;
		longint unsigned q;
		bit expanding, contracting;
		sw = (m_short_len == 0) ? 1 : (m_short_len > SDEPTH) ? SDEPTH : m_short_len;
		lw = (m_long_len == 0) ? 1 : (m_long_len > LDEPTH) ? LDEPTH : m_long_len;
		r = '0;
		r.dev_ratio = RATIO_ONE;
		if (short_head >= sw) short_head = 0;
		if (long_head >= lw) long_head = 0;
		short_mem[short_head] = s;
		short_head = (short_head + 1) % sw;
		if (short_fill < sw) short_fill++;
		long_mem[long_head] = s;
		long_head = (long_head + 1) % lw;
		if (long_fill < lw) long_fill++;
		if (long_fill >= m_min_fill) begin
			r.short_dev = window_spread(0, short_fill);
			r.long_dev = window_spread(1, long_fill);
			if (r.long_dev != 0) begin
				q = (longint'(r.short_dev) << 8) / r.long_dev;
				r.dev_ratio = (q > 65535) ? RATIO_MAX : 16'(q);
			end
			expanding = r.dev_ratio > m_breakout;
			contracting = r.dev_ratio < m_contraction;
			if (expanding && !was_expanding) begin
				r.expansion_event = 1'b1;
				expansion_total++;
			end
			if (contracting && !was_contracting) begin
				r.contraction_event = 1'b1;
				contraction_total++;
			end
			was_expanding = expanding;
			was_contracting = contracting;
		end
		record_total++;
		r.expansion_count = expansion_total;
		r.contraction_count = contraction_total;
		r.sample_count = record_total;
		return r;
	endfunction

	// watchdog counter of cycles since the last accepted transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("%0t watchdog: no request accepted for %0d cycles", $time, WD_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		vol_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = vol_result_t'(m_tdata[145:0]);
			result_count++;
			if (pending_results.size() == 0) begin
				$display("%0t mismatch: unexpected result, expected none actual %h", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("short deviation", want.short_dev, got.short_dev);
				check_field("long deviation", want.long_dev, got.long_dev);
				check_field("ratio", want.dev_ratio, got.dev_ratio);
				check_field("expansion_event", want.expansion_event, got.expansion_event);
				check_field("contraction_event", want.contraction_event, got.contraction_event);
				check_field("expansion_count", want.expansion_count, got.expansion_count);
				check_field("contraction_count", want.contraction_count, got.contraction_count);
				check_field("sample_count", want.sample_count, got.sample_count);
				event_count += got.expansion_event + got.contraction_event;
			end
		end
	end

	// one sample request; known rows replace the deviation, ratio and event fields
	task automatic send_sample(logic [15:0] s, bit known, dir_row_t row);
		vol_result_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		do @(posedge clk); while (!s_tready);
		r = predict_sample(s);
		if (known) begin
			r.short_dev = row.sv;
			r.long_dev = row.lv;
			r.dev_ratio = row.ratio;
			r.expansion_event = row.exp_ev;
			r.contraction_event = row.con_ev;
		end
		pending_results.push_back(r);
	endtask

	// register write, issued only once the engine has drained
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_write(idx, val);
		write_count++;
	endtask

	function automatic logic [15:0] bursty_sample(int amp);
		int v;
		v = $urandom_range(2 * amp) - amp;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	dir_row_t dir_table [] = '{
		// defaults, minimum fill 16: not evaluated yet
		'{ROW_KNOWN,  0, 16'h7FFF, 0, 0, 256, 0, 0},
		'{ROW_KNOWN,  0, 16'h8000, 0, 0, 256, 0, 0},
		'{ROW_KNOWN,  0, 16'h0000, 0, 0, 256, 0, 0},
		'{ROW_KNOWN,  0, 16'hFFFF, 0, 0, 256, 0, 0},
		// zero short window used as one, oversize long window clamped
		'{ROW_WRITE,  CFG_MIN_SAMPLES, 0, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_SHORT_WINDOW, 0, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_LONG_WINDOW, 127, 0, 0, 0, 0, 0},
		'{ROW_KNOWN,  0, 16'h7FFF, 0, 0, 256, 0, 0},
		'{ROW_SAMPLE, 0, 16'h8000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'h7FFF, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'h8000, 0, 0, 0, 0, 0},
		// minimum fill beyond the long window: never evaluated
		'{ROW_WRITE,  CFG_SHORT_WINDOW, 31, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_LONG_WINDOW, 2, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_MIN_SAMPLES, 3, 0, 0, 0, 0, 0},
		'{ROW_KNOWN,  0, 16'd5, 0, 0, 256, 0, 0},
		'{ROW_KNOWN,  0, 16'd100, 0, 0, 256, 0, 0},
		'{ROW_KNOWN,  0, 16'hF000, 0, 0, 256, 0, 0},
		// unknown index is ignored
		'{ROW_WRITE,  5, 16'hFFFF, 0, 0, 0, 0, 0},
		'{ROW_KNOWN,  0, 16'd1, 0, 0, 256, 0, 0},
		// threshold extremes
		'{ROW_WRITE,  CFG_MIN_SAMPLES, 2, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_BREAKOUT_RATIO, 0, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_CONTRACTION_RATIO, 16'hFFFF, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'd1000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'hFC18, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'd7, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_BREAKOUT_RATIO, 16'hFFFF, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_CONTRACTION_RATIO, 0, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_SHORT_WINDOW, 4, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_LONG_WINDOW, 8, 0, 0, 0, 0, 0},
		'{ROW_WRITE,  CFG_MIN_SAMPLES, 8, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'd3, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'hFFFD, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'd2, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'd0, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'd1, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'hFFFF, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'h4000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'hC000, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'h5555, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 16'hAAAA, 0, 0, 0, 0, 0}
	};

	initial begin
		int amp, seg;
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_WRITE)
				write_reg(dir_table[i].index, dir_table[i].value);
			else
				send_sample(dir_table[i].value, dir_table[i].kind == ROW_KNOWN, dir_table[i]);
		end

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
				1: begin sender_idle_pct = 75; recv_stall_pct = 0; end
				2: begin sender_idle_pct = 0; recv_stall_pct = 75; end
				default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				if (ph == 0 && blk == 0) begin
					write_reg(CFG_SHORT_WINDOW, 16);
					write_reg(CFG_LONG_WINDOW, 64);
					write_reg(CFG_MIN_SAMPLES, 64);
					write_reg(CFG_BREAKOUT_RATIO, 300);
					write_reg(CFG_CONTRACTION_RATIO, 200);
				end else begin
					write_reg(CFG_SHORT_WINDOW, $urandom_range(1) ? $urandom_range(8)
						: $urandom_range(16'hFFFF));
					write_reg(CFG_LONG_WINDOW, $urandom_range(1) ? $urandom_range(4, 24)
						: $urandom_range(16'hFFFF));
					write_reg(CFG_MIN_SAMPLES, $urandom_range(3) == 0 ? $urandom_range(127)
						: $urandom_range(12));
					write_reg(CFG_BREAKOUT_RATIO, $urandom_range(3) == 0
						? $urandom_range(16'hFFFF) : $urandom_range(200, 700));
					write_reg(CFG_CONTRACTION_RATIO, $urandom_range(3) == 0
						? $urandom_range(16'hFFFF) : $urandom_range(20, 250));
				end
				// long output hold-off while samples keep coming
				if (ph == 0 && blk == 1) hold_cycles = 3000;
				for (int k = 0; k < 42; k += seg) begin
					seg = $urandom_range(3, 12);
					case ($urandom_range(4))
						0: amp = 16;
						1: amp = 256;
						2: amp = 2048;
						3: amp = 8192;
						default: amp = 32768;
					endcase
					for (int j = 0; j < seg; j++)
						send_sample(bursty_sample(amp), 0, dir_table[0]);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0) fail_count++;
		$display("covered %0d results, %0d events, %0d register writes,", result_count,
			event_count, write_count);
		$display("window clamps, late evaluation, threshold extremes and stream stalls");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
